### src/rtga_pkg.sv
`default_nettype none

package rtga_pkg;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_END = 1'b1
	} op_t;

	typedef enum logic {
		KIND_NAME = 1'b0,
		KIND_TEXT = 1'b1
	} kind_t;

	localparam logic [0:0] REG_PROGRAM_ID   = 1'b0;
	localparam logic [0:0] REG_PROGRAM_TYPE = 1'b1;

	// message position: segment * 4 + fill (text) or segment * 2 + fill (name) fits in 7 bits
	localparam int ACC_W = 7;

	localparam logic [15:0] BLOCK3_NAME = 16'hE0CD;
	localparam logic [15:0] MUSIC_FLAG  = 16'h0008;
	localparam logic [15:0] GROUP_2A    = 16'h2000;

	typedef struct packed {
		op_t        op;
		logic [7:0] character;
		kind_t      kind;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} item_req_t;

	typedef struct packed {
		logic [15:0] block_one;
		logic [15:0] block_two;
		logic [15:0] block_three;
		logic [15:0] block_four;
		logic        last_group;
	} group_t;

endpackage

`default_nettype wire

### src/rtga_in_stage.sv
`default_nettype none

module rtga_in_stage import rtga_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire item_t     item,
	output logic           in_stall,
	input  wire logic      hold,
	output item_req_t      req_s1
);

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	assign in_stall = valid_s1 && hold;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!hold) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	assign req_s1 = '{valid: valid_s1, item: item_s1};

endmodule

`default_nettype wire

### src/rtga_packer.sv
`default_nettype none

module rtga_packer import rtga_pkg::*; #(
	parameter int NAME_CHARS = 8,
	parameter int TEXT_CHARS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire item_req_t   req_s1,
	output logic             hold,
	input  wire logic [15:0] program_id,
	input  wire logic [4:0]  program_type,
	output group_t           group_q,
	output logic             out_valid,
	input  wire logic        out_stall
);

	localparam logic [ACC_W-1:0] NAME_CAP = ACC_W'(NAME_CHARS);
	localparam logic [ACC_W-1:0] TEXT_CAP = ACC_W'(TEXT_CHARS);

	logic [3:0][7:0] chars_q;
	logic [1:0]      fill_q;
	logic [4:0]      seg_q;
	kind_t           kind_q;
	logic            out_valid_q;

	kind_t            kind_eff;
	logic [ACC_W-1:0] cap;
	logic [ACC_W-1:0] acc;
	logic [ACC_W-1:0] acc_inc;
	logic             full;
	logic [2:0]       used;
	logic             group_full;
	logic [3:0][7:0]  chars_new;
	logic [3:0][7:0]  chars_src;
	logic [3:0][7:0]  chars_out;
	logic [2:0]       count_out;
	logic             emit;
	logic             last;
	logic [3:0][7:0]  chars_n;
	logic [1:0]       fill_n;
	logic [4:0]       seg_n;
	logic             process;
	group_t           group_n;

	assign hold    = out_valid_q && out_stall;
	assign process = req_s1.valid && !hold;

	always_comb begin
		// kind is sampled only at the start of a message
		kind_eff = (seg_q == 5'd0 && fill_q == 2'd0) ? req_s1.item.kind : kind_q;
		if (kind_eff == KIND_TEXT) begin
			cap = TEXT_CAP;
			acc = {seg_q, 2'b00} + ACC_W'(fill_q);
		end else begin
			cap = NAME_CAP;
			acc = {1'b0, seg_q, 1'b0} + ACC_W'(fill_q);
		end
		full       = acc >= cap;
		acc_inc    = acc + ACC_W'(1);
		used       = {1'b0, fill_q} + 3'd1;
		group_full = (kind_eff == KIND_TEXT) ? (used == 3'd4) : (used >= 3'd2);

		chars_new         = chars_q;
		chars_new[fill_q] = req_s1.item.character;

		emit      = 1'b0;
		last      = 1'b0;
		count_out = 3'd0;
		chars_src = chars_q;
		chars_n   = chars_q;
		fill_n    = fill_q;
		seg_n     = seg_q;

		if (req_s1.item.op == OP_ADD) begin
			if (!full) begin
				chars_src = chars_new;
				if (group_full || acc_inc >= cap) begin
					emit      = 1'b1;
					last      = acc_inc >= cap;
					count_out = used;
					chars_n   = '0;
					fill_n    = 2'd0;
					seg_n     = seg_q + 5'd1;
				end else begin
					chars_n = chars_new;
					fill_n  = used[1:0];
				end
			end
		end else begin
			// end of message: null-terminate unless capacity was reached
			emit      = !full;
			last      = 1'b1;
			count_out = {1'b0, fill_q};
			chars_n   = '0;
			fill_n    = 2'd0;
			seg_n     = 5'd0;
		end

		for (int k = 0; k < 4; k++) begin
			chars_out[k] = (3'(k) < count_out) ? chars_src[k] : 8'h00;
		end

		group_n.block_one  = program_id;
		group_n.last_group = last;
		if (kind_eff == KIND_TEXT) begin
			group_n.block_two   = GROUP_2A | (16'(program_type) << 5) | 16'(seg_q[3:0]);
			group_n.block_three = {chars_out[0], chars_out[1]};
			group_n.block_four  = {chars_out[2], chars_out[3]};
		end else begin
			group_n.block_two   = (16'(program_type) << 5) | MUSIC_FLAG | 16'(seg_q[1:0]);
			group_n.block_three = BLOCK3_NAME;
			group_n.block_four  = {chars_out[0], chars_out[1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q     <= '0;
			fill_q      <= 2'd0;
			seg_q       <= 5'd0;
			kind_q      <= KIND_NAME;
			out_valid_q <= 1'b0;
		end else begin
			if (process) begin
				chars_q     <= chars_n;
				fill_q      <= fill_n;
				seg_q       <= seg_n;
				kind_q      <= kind_eff;
				out_valid_q <= emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (process && emit) begin
			group_q <= group_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### src/rds_text_group_assembler_core.sv
// A request accepted into the input register reaches out_valid through the packer's result register.
// Throughput: one request per cycle unless a stalled group holds the input; counter next state is combinational.
// A request is taken while a finished group waits, as long as the input register is free.
// Reset (arst_n low, asynchronous): counters, pending characters, kind and valids clear;
// program_id and program_type return to zero.
`default_nettype none

module rds_text_group_assembler_core import rtga_pkg::*; #(
	parameter int NAME_CHARS = 8,
	parameter int TEXT_CHARS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// character / end-of-message requests
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [7:0]  character,
	input  wire logic        message_kind,
	// assembled groups
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      block_one,
	output logic [15:0]      block_two,
	output logic [15:0]      block_three,
	output logic [15:0]      block_four,
	output logic             last_group
);

	logic [15:0] program_id_q;
	logic [4:0]  program_type_q;
	item_t       item;
	item_req_t   req_s1;
	logic        hold;
	group_t      group_q;

	// config must be written only while idle (the block does not enforce this), so the packer reads it directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_id_q   <= 16'd0;
			program_type_q <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROGRAM_ID:   program_id_q   <= cfg_data;
				REG_PROGRAM_TYPE: program_type_q <= cfg_data[4:0];
			endcase
		end
	end

	assign item = '{op: op_t'(operation), character: character, kind: kind_t'(message_kind)};

	// input register: holds one request while the output is stalled
	rtga_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item     (item),
		.in_stall (in_stall),
		.hold     (hold),
		.req_s1   (req_s1)
	);

	// group state, block composition and result register
	rtga_packer #(
		.NAME_CHARS (NAME_CHARS),
		.TEXT_CHARS (TEXT_CHARS)
	) u_packer (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_s1       (req_s1),
		.hold         (hold),
		.program_id   (program_id_q),
		.program_type (program_type_q),
		.group_q      (group_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

	assign block_one   = group_q.block_one;
	assign block_two   = group_q.block_two;
	assign block_three = group_q.block_three;
	assign block_four  = group_q.block_four;
	assign last_group  = group_q.last_group;

endmodule

`default_nettype wire

### src/rtga_checker.sv
`default_nettype none

module rtga_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] block_one,
	input wire logic [15:0] block_two,
	input wire logic [15:0] block_three,
	input wire logic [15:0] block_four,
	input wire logic        last_group
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("group dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(block_one) && $stable(block_two)
			&& $stable(block_three) && $stable(block_four) && $stable(last_group))
		else $error("group changed while stalled");

	a_name_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !block_two[13] |-> block_three == 16'hE0CD && block_two[3]
			&& block_two[2] == 1'b0)
		else $error("bad 0A group layout");

	a_type_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> block_two[15:14] == 2'b00 && block_two[12:10] == 3'b000
			&& (block_two[13] || block_two[4] == 1'b0))
		else $error("bad group type bits");

	// input only backs up behind a stalled group
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting group");

endmodule

bind rds_text_group_assembler_core rtga_checker u_rtga_checker (.*);

`default_nettype wire
